/* design/gde_pkg.sv */
`default_nettype none

package gde_pkg;

  // sequencer state codes
  localparam logic [2:0] ST_CLEAR = 3'd0;
  localparam logic [2:0] ST_IDLE  = 3'd1;
  localparam logic [2:0] ST_PROBE = 3'd2;
  localparam logic [2:0] ST_CHECK = 3'd3;
  localparam logic [2:0] ST_POP   = 3'd4;
  localparam logic [2:0] ST_LOAD  = 3'd5;

  // operation codes
  localparam logic OP_START  = 1'b0;
  localparam logic OP_REPORT = 1'b1;

  // neighbour order: west, south, east, north
  localparam logic [1:0] DIR_WEST  = 2'd0;
  localparam logic [1:0] DIR_SOUTH = 2'd1;
  localparam logic [1:0] DIR_EAST  = 2'd2;
  localparam logic [1:0] DIR_NORTH = 2'd3;

  // visit numbering
  localparam logic [6:0] COUNTER_FIRST = 7'd1;
  localparam logic [6:0] COUNTER_MAX   = 7'd127;

  localparam logic [9:0] THRESHOLD_RESET = 10'd512;

endpackage

`default_nettype wire

/* design/gde_ram.sv */
`default_nettype none

module gde_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 64
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // one write port, registered read port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

`default_nettype wire

/* design/grid_dfs_explorer_unit.sv */
// Depth-first grid explorer, one result beat per accepted command.
// Start: result in the cycle after accept, then busy while the seen map is swept clear.
// Report: result after four direction probes, one check (read of the seen RAM) per
// in-grid neighbour, a stack pop and, unless done, a load of the popped cell.
// Reset (synchronous, active high) runs the same clear sweep over all GRID_SIDE*GRID_SIDE cells.
// The receiver cannot stall: each result is shown for one cycle with result_valid.
`default_nettype none

module grid_dfs_explorer_unit
  import gde_pkg::*;
#(
  parameter int GRID_SIDE   = 8,
  parameter int STACK_DEPTH = 64
) (
  input  wire logic       clk,
  input  wire logic       rst,
  input  wire logic       start,
  output logic            busy,
  input  wire logic       operation,
  input  wire logic [2:0] start_x,
  input  wire logic [2:0] start_y,
  input  wire logic [9:0] sensor_value,
  input  wire logic       cfg_valid,
  output logic            cfg_ready,
  input  wire logic [9:0] cfg_data,
  output logic            result_valid,
  output logic [2:0]      next_x,
  output logic [2:0]      next_y,
  output logic            done_res,
  output logic [6:0]      mapped_number,
  output logic            was_wall
);

  localparam int CELLS = GRID_SIDE * GRID_SIDE;
  localparam int XW    = $clog2(GRID_SIDE);
  localparam int CAW   = $clog2(CELLS);
  localparam int SAW   = $clog2(STACK_DEPTH);
  localparam int CNW   = $clog2(STACK_DEPTH + 1);
  localparam logic [CAW-1:0] SIDE_C    = CAW'(GRID_SIDE);
  localparam logic [CAW-1:0] LAST_CELL = CAW'(CELLS - 1);
  localparam logic [XW-1:0]  LAST_XY   = XW'(GRID_SIDE - 1);
  localparam logic [CNW-1:0] FULL_CNT  = CNW'(STACK_DEPTH);

  logic [2:0]      state;
  logic [CAW-1:0]  clr_addr;
  logic [1:0]      dir;
  logic [XW-1:0]   cur_x;
  logic [XW-1:0]   cur_y;
  logic [CNW-1:0]  stack_count;
  logic [6:0]      visit_counter;
  logic [9:0]      wall_threshold;

  logic            accept;
  logic [31:0]     sx32;
  logic [31:0]     sy32;
  logic [XW-1:0]   nb_x;
  logic [XW-1:0]   nb_y;
  logic            nb_in;
  logic [CAW-1:0]  cur_addr;
  logic [CAW-1:0]  nb_addr;
  logic [CNW-1:0]  cnt_dec;
  logic [XW+2:0]   ext_x;
  logic [XW+2:0]   ext_y;

  logic            seen_we;
  logic [CAW-1:0]  seen_waddr;
  logic            seen_wdata;
  logic            seen_rdata;
  logic            stk_we;
  logic [2*XW-1:0] stk_rdata;

  assign accept    = start && !busy;
  assign busy      = (state != ST_IDLE);
  assign cfg_ready = 1'b1;

  // start coordinates clamped into the grid
  assign sx32 = ({29'd0, start_x} >= 32'(GRID_SIDE)) ? 32'(GRID_SIDE - 1) : {29'd0, start_x};
  assign sy32 = ({29'd0, start_y} >= 32'(GRID_SIDE)) ? 32'(GRID_SIDE - 1) : {29'd0, start_y};

  // neighbour under test and its bounds check
  always_comb begin
    nb_x  = cur_x;
    nb_y  = cur_y;
    nb_in = 1'b0;
    case (dir)
      DIR_WEST: begin
        nb_x  = cur_x - 1'b1;
        nb_in = (cur_x != '0);
      end
      DIR_SOUTH: begin
        nb_y  = cur_y - 1'b1;
        nb_in = (cur_y != '0);
      end
      DIR_EAST: begin
        nb_x  = cur_x + 1'b1;
        nb_in = (cur_x != LAST_XY);
      end
      default: begin
        nb_y  = cur_y + 1'b1;
        nb_in = (cur_y != LAST_XY);
      end
    endcase
  end

  assign cur_addr = CAW'(cur_x) * SIDE_C + CAW'(cur_y);
  assign nb_addr  = CAW'(nb_x) * SIDE_C + CAW'(nb_y);
  assign cnt_dec  = stack_count - 1'b1;

  // seen map write port: clear sweep, mark on report, mark of each unseen neighbour
  always_comb begin
    seen_we    = 1'b0;
    seen_waddr = cur_addr;
    seen_wdata = 1'b1;
    stk_we     = 1'b0;
    unique case (state)
      ST_CLEAR: begin
        seen_we    = 1'b1;
        seen_waddr = clr_addr;
        seen_wdata = 1'b0;
      end
      ST_IDLE: begin
        seen_we = accept && (operation == OP_REPORT);
      end
      ST_CHECK: begin
        seen_we    = !seen_rdata;
        seen_waddr = nb_addr;
        stk_we     = !seen_rdata && (stack_count < FULL_CNT);
      end
      default: begin
        seen_we = 1'b0;
      end
    endcase
  end

  gde_ram #(
    .WIDTH(1),
    .DEPTH(CELLS)
  ) u_seen_ram (
    .clk  (clk),
    .we   (seen_we),
    .waddr(seen_waddr),
    .wdata(seen_wdata),
    .raddr(nb_addr),
    .rdata(seen_rdata)
  );

  gde_ram #(
    .WIDTH(2 * XW),
    .DEPTH(STACK_DEPTH)
  ) u_stack_ram (
    .clk  (clk),
    .we   (stk_we),
    .waddr(stack_count[SAW-1:0]),
    .wdata({nb_x, nb_y}),
    .raddr(cnt_dec[SAW-1:0]),
    .rdata(stk_rdata)
  );

  // configuration register
  always_ff @(posedge clk) begin
    if (rst) begin
      wall_threshold <= THRESHOLD_RESET;
    end else if (cfg_valid && cfg_ready) begin
      wall_threshold <= cfg_data;
    end
  end

  assign ext_x = {3'd0, stk_rdata[2*XW-1:XW]};
  assign ext_y = {3'd0, stk_rdata[XW-1:0]};

  // sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= ST_CLEAR;
      clr_addr      <= '0;
      dir           <= DIR_WEST;
      cur_x         <= '0;
      cur_y         <= '0;
      stack_count   <= '0;
      visit_counter <= COUNTER_FIRST;
      result_valid  <= 1'b0;
    end else begin
      result_valid <= 1'b0;
      unique case (state)
        ST_CLEAR: begin
          clr_addr <= clr_addr + 1'b1;
          if (clr_addr == LAST_CELL) begin
            state <= ST_IDLE;
          end
        end
        ST_IDLE: begin
          if (accept && (operation == OP_START)) begin
            cur_x         <= sx32[XW-1:0];
            cur_y         <= sy32[XW-1:0];
            stack_count   <= '0;
            visit_counter <= COUNTER_FIRST;
            next_x        <= sx32[2:0];
            next_y        <= sy32[2:0];
            done_res      <= 1'b0;
            mapped_number <= '0;
            was_wall      <= 1'b0;
            result_valid  <= 1'b1;
            clr_addr      <= '0;
            state         <= ST_CLEAR;
          end else if (accept) begin
            dir <= DIR_WEST;
            if (sensor_value > wall_threshold) begin
              was_wall      <= 1'b1;
              mapped_number <= '0;
            end else begin
              was_wall      <= 1'b0;
              mapped_number <= visit_counter;
              if (visit_counter != COUNTER_MAX) begin
                visit_counter <= visit_counter + 1'b1;
              end
            end
            state <= ST_PROBE;
          end
        end
        ST_PROBE: begin
          if (nb_in) begin
            state <= ST_CHECK;
          end else if (dir == DIR_NORTH) begin
            state <= ST_POP;
          end else begin
            dir <= dir + 1'b1;
          end
        end
        ST_CHECK: begin
          if (stk_we) begin
            stack_count <= stack_count + 1'b1;
          end
          if (dir == DIR_NORTH) begin
            state <= ST_POP;
          end else begin
            dir   <= dir + 1'b1;
            state <= ST_PROBE;
          end
        end
        ST_POP: begin
          if (stack_count == '0) begin
            next_x       <= '0;
            next_y       <= '0;
            done_res     <= 1'b1;
            result_valid <= 1'b1;
            state        <= ST_IDLE;
          end else begin
            stack_count <= cnt_dec;
            state       <= ST_LOAD;
          end
        end
        ST_LOAD: begin
          cur_x        <= stk_rdata[2*XW-1:XW];
          cur_y        <= stk_rdata[XW-1:0];
          next_x       <= ext_x[2:0];
          next_y       <= ext_y[2:0];
          done_res     <= 1'b0;
          result_valid <= 1'b1;
          state        <= ST_IDLE;
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

`ifndef SYNTHESIS
  // stack never grows past its depth
  assert property (@(posedge clk) disable iff (rst) stack_count <= FULL_CNT)
    else $error("stack count beyond depth");

  // a report beat keeps the block busy with no result in the next cycle
  assert property (@(posedge clk) disable iff (rst)
    (accept && (operation == OP_REPORT)) |=> (busy && !result_valid))
    else $error("report finished too early");

  // done is only reported with an empty stack
  assert property (@(posedge clk) disable iff (rst)
    (result_valid && done_res) |-> (stack_count == '0))
    else $error("done with entries on the stack");

  // a start beat gives its result next cycle and then sweeps the seen map
  assert property (@(posedge clk) disable iff (rst)
    (accept && (operation == OP_START)) |=> (result_valid && busy && !done_res))
    else $error("start result missing");
`endif

endmodule

`default_nettype wire
